[rtl/bmu_pkg.sv]
// Package: shared transaction types and MIDI constants for the BLE-MIDI parser.
`default_nettype none
package bmu_pkg;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        first_of_write;
    logic        last_of_write;
    logic [15:0] target_handle;
  } in_item_t;

  typedef struct packed {
    logic [3:0] code_index;
    logic [7:0] status_byte;
    logic [7:0] first_data;
    logic [7:0] second_data;
  } out_item_t;

  localparam logic [7:0] SYSEX_START = 8'hF0;
  localparam logic [7:0] SYSEX_END   = 8'hF7;

  localparam logic [3:0] CIN_SYSEX_CONT = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1 = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2 = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3 = 4'h7;

endpackage
`default_nettype wire

[rtl/ble_midi_to_usb_midi_parser.sv]
// Top level: BLE-MIDI byte stream to USB-MIDI event packet converter.
// Each input transaction is held in the input register, and its result, if any, in the output register.
// Throughput: one byte per cycle; the single-pass parser step sits between the
// input and output registers, and a stalled output holds the input once full.
// Reset (rst, synchronous): clears both stage valids, the phase, held fields,
// SysEx flag and the handle register.
`default_nettype none
module ble_midi_to_usb_midi_parser (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bmu_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bmu_pkg::out_item_t      out_data,
  input  wire logic               cfg_wr_en,
  input  wire logic [15:0]        cfg_wr_data
);

  logic               held_valid;
  bmu_pkg::in_item_t  held_item;
  logic               out_free;
  logic               step;
  logic               emit;
  bmu_pkg::out_item_t packet;
  logic [15:0]        value_handle;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_handle <= '0;
    end else if (cfg_wr_en) begin
      value_handle <= cfg_wr_data;
    end
  end

  assign step = held_valid && out_free;

  bmu_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .held_valid (held_valid),
    .held_item  (held_item),
    .take       (step)
  );

  bmu_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .item         (held_item),
    .value_handle (value_handle),
    .emit         (emit),
    .packet       (packet)
  );

  bmu_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (step && emit && (held_item.target_handle == value_handle)),
    .load_item (packet),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

[rtl/bmu_in_stage.sv]
// Input register: captures one input transaction and holds it until the core takes it.
`default_nettype none
module bmu_in_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire bmu_pkg::in_item_t in_data,
  output logic                  held_valid,
  output bmu_pkg::in_item_t     held_item,
  input  wire logic             take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_item <= in_data;
    end
  end

endmodule
`default_nettype wire

[rtl/bmu_core.sv]
// Parser core: phase machine, held message fields and USB-MIDI packet formation.
`default_nettype none
module bmu_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire bmu_pkg::in_item_t item,
  input  wire logic [15:0]       value_handle,
  output logic                   emit,
  output bmu_pkg::out_item_t     packet
);

  typedef enum logic [1:0] {
    NEED_TS     = 2'd0,
    NEED_STATUS = 2'd1,
    NEED_FIRST  = 2'd2,
    NEED_SECOND = 2'd3
  } phase_t;

  phase_t     phase, phase_a, phase_next;
  logic [7:0] status, status_a, status_next;
  logic [7:0] first, first_a, first_next;
  logic [7:0] second, second_a, second_next;
  logic       sysex, sysex_a, sysex_next;
  logic       emit_a, flush, match;
  logic [7:0] src_status, src_first, src_second;
  logic       src_sysex, sysex_after;
  logic [3:0] code;

  assign match = (item.target_handle == value_handle);

  // byte handling before the end-of-write flush
  always_comb begin
    phase_a  = phase;
    status_a = status;
    first_a  = first;
    second_a = second;
    sysex_a  = sysex;
    emit_a   = 1'b0;
    if (item.first_of_write) begin
      phase_a  = NEED_TS;
      status_a = '0;
      first_a  = '0;
      second_a = '0;
    end else if (item.data_byte[7]) begin
      case (phase)
        NEED_TS: phase_a = NEED_STATUS;
        NEED_STATUS: begin
          status_a = item.data_byte;
          if (item.data_byte == bmu_pkg::SYSEX_START) begin
            sysex_a = 1'b1;
          end
          phase_a = NEED_FIRST;
        end
        default: begin
          emit_a  = 1'b1;
          phase_a = NEED_STATUS;
        end
      endcase
    end else begin
      if (phase != NEED_SECOND) begin
        first_a = item.data_byte;
        phase_a = NEED_SECOND;
      end else begin
        second_a = item.data_byte;
        emit_a   = 1'b1;
        phase_a  = NEED_TS;
      end
    end
  end

  assign flush = item.last_of_write && !emit_a && phase_a inside {NEED_FIRST, NEED_SECOND};
  assign emit  = emit_a || flush;

  // emit always sees the values current at that point: the held fields
  // plus any status or data byte that arrived with this item
  assign src_status = status_a;
  assign src_first  = first_a;
  assign src_second = second_a;
  assign src_sysex  = sysex_a;

  always_comb begin
    sysex_after = 1'b0;
    if (src_sysex) begin
      if (src_status == bmu_pkg::SYSEX_END) begin
        code = bmu_pkg::CIN_SYSEX_END1;
      end else if (src_first == bmu_pkg::SYSEX_END) begin
        code = bmu_pkg::CIN_SYSEX_END2;
      end else if (src_second == bmu_pkg::SYSEX_END) begin
        code = bmu_pkg::CIN_SYSEX_END3;
      end else begin
        code        = bmu_pkg::CIN_SYSEX_CONT;
        sysex_after = 1'b1;
      end
    end else begin
      code = src_status[7:4];
    end
  end

  assign packet.code_index  = code;
  assign packet.status_byte = src_status;
  assign packet.first_data  = src_first;
  assign packet.second_data = src_second;

  always_comb begin
    phase_next  = item.last_of_write ? NEED_TS : phase_a;
    status_next = status_a;
    first_next  = emit ? 8'h00 : first_a;
    second_next = emit ? 8'h00 : second_a;
    sysex_next  = emit ? sysex_after : sysex_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= NEED_TS;
      status <= '0;
      first  <= '0;
      second <= '0;
      sysex  <= 1'b0;
    end else if (step && match) begin
      phase  <= phase_next;
      status <= status_next;
      first  <= first_next;
      second <= second_next;
      sysex  <= sysex_next;
    end
  end

endmodule
`default_nettype wire

[rtl/bmu_out_stage.sv]
// Output register: holds one result transaction until the consumer takes it.
`default_nettype none
module bmu_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire bmu_pkg::out_item_t load_item,
  output logic                    free,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bmu_pkg::out_item_t      out_data
);

  assign free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      out_data <= load_item;
    end
  end

endmodule
`default_nettype wire

[rtl/bmu_checker.sv]
// Checker: port-level assertions for the parser, bound to the top level.
`default_nettype none
module bmu_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire bmu_pkg::out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_code_plain: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.code_index != bmu_pkg::CIN_SYSEX_CONT
      && out_data.code_index != bmu_pkg::CIN_SYSEX_END1
      && out_data.code_index != bmu_pkg::CIN_SYSEX_END2
      && out_data.code_index != bmu_pkg::CIN_SYSEX_END3
    |-> out_data.code_index == out_data.status_byte[7:4])
    else $error("code index does not match status");

  a_sysex_end1: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.code_index == bmu_pkg::CIN_SYSEX_END1
    |-> out_data.status_byte == bmu_pkg::SYSEX_END)
    else $error("single-byte SysEx end without end status");

endmodule

bind ble_midi_to_usb_midi_parser bmu_checker u_bmu_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

[tb/tb_ble_midi_to_usb_midi_parser.sv]
// Self-checking testbench for the BLE-MIDI to USB-MIDI event packet parser.
module tb_ble_midi_to_usb_midi_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 4;
  localparam int PHASE_BYTES = 220;

  typedef enum logic [1:0] {PH_TS, PH_STATUS, PH_DATA1, PH_DATA2} parse_phase_t;

  typedef struct {
    bmu_pkg::in_item_t  item;
    bit                 fixed;
    bmu_pkg::out_item_t want;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  bmu_pkg::in_item_t  in_data;
  logic               out_valid;
  logic               out_ready;
  bmu_pkg::out_item_t out_data;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // predicted block state
  logic [15:0]  cfg_handle;
  parse_phase_t phase;
  logic [7:0]   p_status;
  logic [7:0]   p_first;
  logic [7:0]   p_second;
  logic         p_sysex;

  bmu_pkg::out_item_t pkt_q[$];
  dir_row_t           dir_tab[$];

  int src_idle_pct;
  int rcv_stall_pct;
  int hold_req;
  int n_cycles;
  int n_bytes;
  int n_off;
  int n_pkts;
  int n_err;

  ble_midi_to_usb_midi_parser dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bmu_pkg::out_item_t make_packet();
    bmu_pkg::out_item_t p;
    logic [3:0]         cin;
    if (p_sysex) begin
      p_sysex = 1'b0;
      if (p_status == bmu_pkg::SYSEX_END) begin
        cin = bmu_pkg::CIN_SYSEX_END1;
      end else if (p_first == bmu_pkg::SYSEX_END) begin
        cin = bmu_pkg::CIN_SYSEX_END2;
      end else if (p_second == bmu_pkg::SYSEX_END) begin
        cin = bmu_pkg::CIN_SYSEX_END3;
      end else begin
        cin = bmu_pkg::CIN_SYSEX_CONT;
        p_sysex = 1'b1;
      end
    end else begin
      cin = p_status[7:4];
    end
    p = {cin, p_status, p_first, p_second};
    p_first = '0;
    p_second = '0;
    return p;
  endfunction

  task automatic midi_step(input bmu_pkg::in_item_t it, output bit hit,
                           output bmu_pkg::out_item_t pkt);
    logic [7:0] b;
    b = it.data_byte;
    hit = 1'b0;
    pkt = '0;
    if (it.target_handle != cfg_handle) return;
    if (it.first_of_write) begin
      phase = PH_TS;
      p_status = '0;
      p_first = '0;
      p_second = '0;
    end else if (b[7]) begin
      case (phase)
        PH_TS: phase = PH_STATUS;
        PH_STATUS: begin
          p_status = b;
          if (b == bmu_pkg::SYSEX_START) p_sysex = 1'b1;
          phase = PH_DATA1;
        end
        default: begin
          pkt = make_packet();
          hit = 1'b1;
          phase = PH_STATUS;
        end
      endcase
    end else if (phase != PH_DATA2) begin
      p_first = b;
      phase = PH_DATA2;
    end else begin
      p_second = b;
      pkt = make_packet();
      hit = 1'b1;
      phase = PH_TS;
    end
    if (it.last_of_write) begin
      if (!hit && (phase == PH_DATA1 || phase == PH_DATA2)) begin
        pkt = make_packet();
        hit = 1'b1;
      end
      phase = PH_TS;
    end
  endtask

  // offer one byte; a fixed row supplies its own expected packet
  task automatic offer(input bmu_pkg::in_item_t it, input bit fixed = 1'b0,
                       input bmu_pkg::out_item_t want = '0);
    bit                 hit;
    bmu_pkg::out_item_t pkt;
    @(negedge clk);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (it.target_handle == cfg_handle) n_bytes++;
    else n_off++;
    midi_step(it, hit, pkt);
    if (fixed) pkt_q.push_back(want);
    else if (hit) pkt_q.push_back(pkt);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pkt_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_handle(input logic [15:0] h);
    drain();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= h;
    @(posedge clk);
    cfg_handle = h;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // one characteristic write: header, then timestamped messages
  task automatic rand_write(input logic [15:0] h);
    logic [7:0] wb[$];
    logic [7:0] st;
    int kind;
    int nd;
    wb.push_back(8'h80 | 8'($urandom_range(0, 63)));
    repeat ($urandom_range(1, 4)) begin
      kind = $urandom_range(0, 9);
      wb.push_back({1'b1, 7'($urandom)});
      if (kind < 6) begin
        st = {1'b1, 3'($urandom_range(0, 6)), 4'($urandom)};
        wb.push_back(st);
        nd = (st[6:4] == 3'd4 || st[6:4] == 3'd5) ? 1 : 2;
        repeat ($urandom_range(1, 3) * nd) wb.push_back({1'b0, 7'($urandom)});
      end else if (kind < 9) begin
        wb.push_back(bmu_pkg::SYSEX_START);
        repeat ($urandom_range(0, 7)) wb.push_back({1'b0, 7'($urandom)});
        wb.push_back({1'b1, 7'($urandom)});
        wb.push_back(bmu_pkg::SYSEX_END);
      end else begin
        wb.push_back(8'($urandom_range(8'hF1, 8'hFF)));
        wb.push_back({1'b0, 7'($urandom)});
      end
    end
    // truncated write
    if ($urandom_range(0, 9) == 0) wb.delete($urandom_range(0, wb.size() - 1));
    foreach (wb[i]) begin
      if ($urandom_range(0, 19) == 0) offer({8'($urandom), 2'($urandom), 16'($urandom)});
      offer({wb[i], i == 0, i == wb.size() - 1, h});
    end
  endtask

  task automatic noise_burst(input logic [15:0] h);
    repeat ($urandom_range(1, 8)) begin
      offer({8'($urandom), 2'($urandom),
             ($urandom_range(0, 3) == 0) ? 16'($urandom) : h});
    end
  endtask

  function automatic dir_row_t tab_row(logic [7:0] b, logic f, logic l, logic [15:0] h,
                                       bit fx = 1'b0, bmu_pkg::out_item_t w = '0);
    dir_row_t r;
    r.item = {b, f, l, h};
    r.fixed = fx;
    r.want = w;
    return r;
  endfunction

  // sink: random stalls plus a long hold-off on request
  initial begin
    int hold_cnt;
    hold_cnt = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_cnt = hold_req;
        hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
      end
    end
  end

  initial begin
    bmu_pkg::out_item_t exp_pkt;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pkt_q.size() == 0) begin
          $error("unexpected packet %h", out_data);
          n_err++;
        end else begin
          exp_pkt = pkt_q.pop_front();
          n_pkts++;
          if (out_data.code_index != exp_pkt.code_index) begin
            $error("code_index: expected %h, got %h", exp_pkt.code_index, out_data.code_index);
            n_err++;
          end
          if (out_data.status_byte != exp_pkt.status_byte) begin
            $error("status_byte: expected %h, got %h", exp_pkt.status_byte,
                   out_data.status_byte);
            n_err++;
          end
          if (out_data.first_data != exp_pkt.first_data) begin
            $error("first_data: expected %h, got %h", exp_pkt.first_data, out_data.first_data);
            n_err++;
          end
          if (out_data.second_data != exp_pkt.second_data) begin
            $error("second_data: expected %h, got %h", exp_pkt.second_data,
                   out_data.second_data);
            n_err++;
          end
        end
      end
    end
  end

  initial begin
    n_cycles = 0;
    while (n_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      n_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  initial begin
    int src_mix[4];
    int rcv_mix[4];
    logic [15:0] handles[4];
    int target;
    int pick;
    src_mix = '{0, 67, 0, 32};
    rcv_mix = '{0, 0, 67, 32};
    handles = '{16'hFFFF, 16'h0000, 16'($urandom), 16'($urandom)};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    src_idle_pct = 0;
    rcv_stall_pct = 0;
    hold_req = 0;
    n_bytes = 0;
    n_off = 0;
    n_pkts = 0;
    n_err = 0;
    cfg_handle = '0;
    phase = PH_TS;
    p_status = '0;
    p_first = '0;
    p_second = '0;
    p_sysex = 1'b0;

    // no header yet: data bytes parsed from reset state
    dir_tab.push_back(tab_row(8'h40, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h41, 1'b0, 1'b0, 16'h0000, 1'b1,
                              {4'h0, 8'h00, 8'h40, 8'h41}));
    dir_tab.push_back(tab_row(8'h80, 1'b1, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h80, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h90, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h3C, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h7F, 1'b0, 1'b0, 16'h0000, 1'b1,
                              {4'h9, 8'h90, 8'h3C, 8'h7F}));
    // running status; emit and end of write on the same byte
    dir_tab.push_back(tab_row(8'h00, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h7F, 1'b0, 1'b1, 16'h0000, 1'b1,
                              {4'h9, 8'h90, 8'h00, 8'h7F}));
    dir_tab.push_back(tab_row(8'h00, 1'b1, 1'b1, 16'h0000));
    dir_tab.push_back(tab_row(8'h90, 1'b0, 1'b0, 16'hFFFF));
    dir_tab.push_back(tab_row(8'h80, 1'b1, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'hFF, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(bmu_pkg::SYSEX_START, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h01, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h02, 1'b0, 1'b0, 16'h0000, 1'b1,
                              {bmu_pkg::CIN_SYSEX_CONT, bmu_pkg::SYSEX_START, 8'h01, 8'h02}));
    dir_tab.push_back(tab_row(8'h03, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h81, 1'b0, 1'b1, 16'h0000, 1'b1,
                              {bmu_pkg::CIN_SYSEX_CONT, bmu_pkg::SYSEX_START, 8'h03, 8'h00}));
    // SysEx flag carried into the next write
    dir_tab.push_back(tab_row(8'h80, 1'b1, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h80, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(bmu_pkg::SYSEX_END, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'h7F, 1'b0, 1'b1, 16'h0000, 1'b1,
                              {bmu_pkg::CIN_SYSEX_END1, bmu_pkg::SYSEX_END, 8'h7F, 8'h00}));
    // flush with status only
    dir_tab.push_back(tab_row(8'hA5, 1'b1, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'hFF, 1'b0, 1'b0, 16'h0000));
    dir_tab.push_back(tab_row(8'hE3, 1'b0, 1'b1, 16'h0000, 1'b1,
                              {4'hE, 8'hE3, 8'h00, 8'h00}));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_tab[i]) offer(dir_tab[i].item, dir_tab[i].fixed, dir_tab[i].want);

    // long sink hold-off while the source keeps pushing note data
    hold_req = 300;
    offer({8'h80, 1'b1, 1'b0, cfg_handle});
    offer({8'h80, 1'b0, 1'b0, cfg_handle});
    offer({8'h90, 1'b0, 1'b0, cfg_handle});
    repeat (60) offer({1'b0, 7'($urandom), 2'b00, cfg_handle});
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      set_handle(handles[ph]);
      src_idle_pct = src_mix[ph];
      rcv_stall_pct = rcv_mix[ph];
      target = n_bytes + PHASE_BYTES;
      while (n_bytes < target) begin
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
          noise_burst(cfg_handle);
        end else if (pick == 2) begin
          rand_write(cfg_handle ^ 16'($urandom_range(1, 65535)));
        end else begin
          rand_write(cfg_handle);
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Checked %0d USB-MIDI packets from %0d parsed bytes; %0d off-handle bytes dropped.",
             n_pkts, n_bytes, n_off);
    $display("Four handle settings incl. 0x0000/0xFFFF, four stall mixes, one long sink hold-off.");
    if (n_err == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
